// ===== hw/rtl/dzod_pkg.sv =====
// Package: shared types, codes and constants of the disparity zone obstacle detector.
`timescale 1ns / 1ps

package dzod_pkg;

  // Frame limits; pixels beyond these are not counted.
  localparam int unsigned MaxWidth  = 2048;
  localparam int unsigned MaxHeight = 2048;

  localparam int unsigned CntW   = 23;
  localparam int unsigned CfgW   = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NumW   = 33;  // weight * negatives + 256 * highs
  localparam int unsigned DenW   = 24;  // rows * zone width
  localparam int unsigned HalfW  = 17;  // upper operand slice of the shared multiplier
  localparam int unsigned PpW    = HalfW + DenW;
  localparam int unsigned CrossW = NumW + DenW;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
  localparam logic [6:0] PercentScale = 7'd100;

  localparam logic [11:0] FrameWidthRst     = 12'd640;
  localparam logic [11:0] CountedRowsRst    = 12'd360;
  localparam logic [11:0] CenterBeginRst    = 12'd160;
  localparam logic [11:0] CenterEndRst      = 12'd544;
  localparam logic [7:0]  HighThresholdRst  = 8'd75;
  localparam logic [8:0]  NegativeWeightRst = 9'd77;
  localparam logic [6:0]  CenterPercentRst  = 7'd30;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth     = 3'd0,
    CfgCountedRows    = 3'd1,
    CfgCenterBegin    = 3'd2,
    CfgCenterEnd      = 3'd3,
    CfgHighThreshold  = 3'd4,
    CfgNegativeWeight = 3'd5,
    CfgCenterPercent  = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DirStraight = 2'd0,
    DirPlus     = 2'd1,
    DirMinus    = 2'd2
  } dir_e;

  typedef enum logic [3:0] {
    StCount = 4'd0,
    StPrep  = 4'd1,
    StScore = 4'd2,
    StBlock = 4'd3,
    StMul0  = 4'd4,
    StMul1  = 4'd5,
    StMul2  = 4'd6,
    StMul3  = 4'd7,
    StDone  = 4'd8
  } state_e;

  typedef struct packed {
    logic signed [8:0] disparity;
    logic [10:0]       row;
    logic [10:0]       col;
    logic              end_of_frame;
  } pixel_t;

  typedef struct packed {
    dir_e            direction;
    logic            center_blocked;
    logic [CntW-1:0] center_high_count;
    logic [CntW-1:0] center_negative_count;
  } result_t;

  typedef struct packed {
    logic       count;
    logic       prep;
    logic       score;
    logic       block;
    logic       mul;
    logic [1:0] mul_step;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/dzod_stream_if.sv =====
// Interface: valid/ready stream channel carrying one beat of a given type.
`timescale 1ns / 1ps

interface dzod_stream_if #(
  parameter type beat_t = logic
) ();
  logic  valid;
  logic  ready;
  beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/disparity_zone_obstacle_detector_unit.sv =====
// Top level: disparity zone obstacle detector, controller plus datapath.
`timescale 1ns / 1ps

// Pixels are taken one per cycle while a frame streams in. The beat flagged
// end_of_frame is counted and then starts the decision, which holds the
// input off through register stages for zone scores and the blocked test,
// four passes through the shared 17x24 multiplier for the side cross
// products and one load of the result register, and for as long as the result
// register stays full from the previous frame. The user must see to it that
// registers are written only while no frame decision is pending; the block does not enforce it.
module disparity_zone_obstacle_detector_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  dzod_stream_if.sink                  pixel_in,
  dzod_stream_if.source                result_out,
  input  logic                         cfg_we_i,
  input  logic [dzod_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dzod_pkg::CfgW-1:0]    cfg_data_i
);

  dzod_pkg::cmd_t    cmd;
  dzod_pkg::status_t status;
  dzod_pkg::pixel_t  pix;
  dzod_pkg::result_t res;

  assign pix = pixel_in.data;
  assign result_out.data = res;

  dzod_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pixel_in.valid),
    .eof_i      (pix.end_of_frame),
    .in_ready_o (pixel_in.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dzod_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pix_i       (pix),
    .res_o       (res),
    .res_valid_o (result_out.valid),
    .res_ready_i (result_out.ready)
  );

endmodule

// ===== hw/rtl/dzod_ctrl.sv =====
// Controller: sequences pixel counting and the end-of-frame decision.
`timescale 1ns / 1ps

module dzod_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             eof_i,
  output logic             in_ready_o,
  input  dzod_pkg::status_t status_i,
  output dzod_pkg::cmd_t   cmd_o
);

  dzod_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dzod_pkg::StCount;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dzod_pkg::StCount: begin
        if (in_valid_i && eof_i) state_d = dzod_pkg::StPrep;
      end
      dzod_pkg::StPrep:  state_d = dzod_pkg::StScore;
      dzod_pkg::StScore: state_d = dzod_pkg::StBlock;
      dzod_pkg::StBlock: state_d = dzod_pkg::StMul0;
      dzod_pkg::StMul0:  state_d = dzod_pkg::StMul1;
      dzod_pkg::StMul1:  state_d = dzod_pkg::StMul2;
      dzod_pkg::StMul2:  state_d = dzod_pkg::StMul3;
      dzod_pkg::StMul3:  state_d = dzod_pkg::StDone;
      dzod_pkg::StDone: begin
        if (status_i.out_free) state_d = dzod_pkg::StCount;
      end
      default: state_d = dzod_pkg::StCount;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      dzod_pkg::StCount: begin
        in_ready_o   = 1'b1;
        cmd_o.count  = in_valid_i;
      end
      dzod_pkg::StPrep:  cmd_o.prep  = 1'b1;
      dzod_pkg::StScore: cmd_o.score = 1'b1;
      dzod_pkg::StBlock: cmd_o.block = 1'b1;
      dzod_pkg::StMul0: begin
        cmd_o.mul      = 1'b1;
        cmd_o.mul_step = 2'd0;
      end
      dzod_pkg::StMul1: begin
        cmd_o.mul      = 1'b1;
        cmd_o.mul_step = 2'd1;
      end
      dzod_pkg::StMul2: begin
        cmd_o.mul      = 1'b1;
        cmd_o.mul_step = 2'd2;
      end
      dzod_pkg::StMul3: begin
        cmd_o.mul      = 1'b1;
        cmd_o.mul_step = 2'd3;
      end
      dzod_pkg::StDone: cmd_o.finish = status_i.out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_eof_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && eof_i) |=> !in_ready_o)
    else $error("input still ready after end-of-frame beat");
  a_finish_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> status_i.out_free)
    else $error("result loaded while output register full");
  a_no_count_in_decision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.prep || cmd_o.score || cmd_o.block || cmd_o.mul) |-> !cmd_o.count)
    else $error("pixel counted during decision");
`endif

endmodule

// ===== hw/rtl/dzod_datapath.sv =====
// Datapath: configuration, zone counters, score arithmetic and result register.
`timescale 1ns / 1ps

module dzod_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dzod_pkg::cmd_t                   cmd_i,
  output dzod_pkg::status_t                status_o,
  input  logic                             cfg_we_i,
  input  logic [dzod_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [dzod_pkg::CfgW-1:0]        cfg_data_i,
  input  dzod_pkg::pixel_t                 pix_i,
  output dzod_pkg::result_t                res_o,
  output logic                             res_valid_o,
  input  logic                             res_ready_i
);

  localparam int unsigned CntW   = dzod_pkg::CntW;
  localparam int unsigned NumW   = dzod_pkg::NumW;
  localparam int unsigned DenW   = dzod_pkg::DenW;
  localparam int unsigned PpW    = dzod_pkg::PpW;
  localparam int unsigned CrossW = dzod_pkg::CrossW;

  // configuration
  logic [11:0] fw_q, rows_q, cb_q, ce_q;
  logic [7:0]  thr_q;
  logic [8:0]  wgt_q;
  logic [6:0]  pct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= dzod_pkg::FrameWidthRst;
      rows_q <= dzod_pkg::CountedRowsRst;
      cb_q   <= dzod_pkg::CenterBeginRst;
      ce_q   <= dzod_pkg::CenterEndRst;
      thr_q  <= dzod_pkg::HighThresholdRst;
      wgt_q  <= dzod_pkg::NegativeWeightRst;
      pct_q  <= dzod_pkg::CenterPercentRst;
    end else if (cfg_we_i) begin
      case (dzod_pkg::cfg_idx_e'(cfg_index_i))
        dzod_pkg::CfgFrameWidth:     fw_q   <= cfg_data_i;
        dzod_pkg::CfgCountedRows:    rows_q <= cfg_data_i;
        dzod_pkg::CfgCenterBegin:    cb_q   <= cfg_data_i;
        dzod_pkg::CfgCenterEnd:      ce_q   <= cfg_data_i;
        dzod_pkg::CfgHighThreshold:  thr_q  <= cfg_data_i[7:0];
        dzod_pkg::CfgNegativeWeight: wgt_q  <= cfg_data_i[8:0];
        dzod_pkg::CfgCenterPercent:  pct_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // zone bounds
  logic [11:0] zb, ze_lo, ze;
  logic [2:0][11:0] zw;
  always_comb begin
    zb    = (cb_q < fw_q) ? cb_q : fw_q;
    ze_lo = (ce_q < zb) ? zb : ce_q;
    ze    = (ze_lo > fw_q) ? fw_q : ze_lo;
    zw[0] = zb;
    zw[1] = ze - zb;
    zw[2] = fw_q - ze;
  end

  // pixel zone select
  logic [11:0] col12, row12;
  logic        in_frame;
  logic [2:0]  hit;
  always_comb begin
    col12    = {1'b0, pix_i.col};
    row12    = {1'b0, pix_i.row};
    in_frame = (row12 < rows_q)
            && (14'(pix_i.row) < 14'(dzod_pkg::MaxHeight))
            && (14'(pix_i.col) < 14'(dzod_pkg::MaxWidth));
    hit = '0;
    if (in_frame) begin
      if (col12 < zb)        hit[0] = 1'b1;
      else if (col12 < ze)   hit[1] = 1'b1;
      else if (col12 < fw_q) hit[2] = 1'b1;
    end
  end

  logic is_neg, is_high;
  assign is_neg  = pix_i.disparity[8];
  assign is_high = !pix_i.disparity[8] && (pix_i.disparity[7:0] >= thr_q);

  // zone counters, index 0 left, 1 center, 2 right
  logic [2:0][CntW-1:0] neg_q, high_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q  <= '0;
      high_q <= '0;
    end else if (cmd_i.finish) begin
      neg_q  <= '0;
      high_q <= '0;
    end else if (cmd_i.count) begin
      for (int z = 0; z < 3; z++) begin
        if (hit[z]) begin
          if (is_neg && neg_q[z] != dzod_pkg::CntMax) neg_q[z] <= neg_q[z] + 1'b1;
          if (is_high && high_q[z] != dzod_pkg::CntMax) high_q[z] <= high_q[z] + 1'b1;
        end
      end
    end
  end

  // score numerators and denominators
  logic [2:0][NumW-1:0] num_q;
  logic [2:0][DenW-1:0] den_q;
  logic [2:0][DenW-1:0] tot;
  logic [2:0][31:0]     wprod;
  always_comb begin
    for (int z = 0; z < 3; z++) begin
      tot[z]   = DenW'(rows_q) * DenW'(zw[z]);
      wprod[z] = 32'(wgt_q) * 32'(neg_q[z]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      for (int z = 0; z < 3; z++) begin
        if (tot[z] == '0) begin
          num_q[z] <= '0;
          den_q[z] <= DenW'(1);
        end else begin
          num_q[z] <= NumW'(wprod[z]) + NumW'({high_q[z], 8'b0});
          den_q[z] <= tot[z];
        end
      end
    end
  end

  // center blocked test: num * 100 >= pct * 256 * den
  logic [NumW+6:0] lhs_q;
  logic [NumW+5:0] rhs_q;
  logic [30:0]     pct_den;
  logic            blocked_q;
  assign pct_den = 31'(pct_q) * 31'(den_q[1]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.score) begin
      lhs_q <= (NumW+7)'(num_q[1]) * (NumW+7)'(dzod_pkg::PercentScale);
      rhs_q <= {pct_den, 8'b0};
    end
    if (cmd_i.block) begin
      blocked_q <= lhs_q >= {1'b0, rhs_q};
    end
  end

  // side cross products on one shared multiplier, two slices each
  logic [NumW-1:0]   opa;
  logic [DenW-1:0]   opb;
  logic [dzod_pkg::HalfW-1:0] half;
  logic [PpW-1:0]    pp;
  logic [CrossW-1:0] ext;
  logic [CrossW-1:0] acc_l_q, acc_r_q;
  always_comb begin
    opa  = cmd_i.mul_step[1] ? num_q[2] : num_q[0];
    opb  = cmd_i.mul_step[1] ? den_q[0] : den_q[2];
    half = cmd_i.mul_step[0] ? opa[NumW-1:16] : {1'b0, opa[15:0]};
    pp   = PpW'(half) * PpW'(opb);
    ext  = cmd_i.mul_step[0] ? {pp, 16'b0} : CrossW'(pp);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      if (!cmd_i.mul_step[1]) begin
        acc_l_q <= cmd_i.mul_step[0] ? acc_l_q + ext : ext;
      end else begin
        acc_r_q <= cmd_i.mul_step[0] ? acc_r_q + ext : ext;
      end
    end
  end

  // result register
  logic res_valid_q;
  dzod_pkg::result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (!blocked_q)             res_q.direction <= dzod_pkg::DirStraight;
      else if (acc_l_q < acc_r_q) res_q.direction <= dzod_pkg::DirPlus;
      else                        res_q.direction <= dzod_pkg::DirMinus;
      res_q.center_blocked        <= blocked_q;
      res_q.center_high_count     <= high_q[1];
      res_q.center_negative_count <= neg_q[1];
    end
  end

  assign res_o             = res_q;
  assign res_valid_o       = res_valid_q;
  assign status_o.out_free = !res_valid_q || res_ready_i;

`ifndef ASSERT_OFF
  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(cmd_i.finish))
    else $error("result valid without a decision");
  a_turn_only_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ((res_q.direction != dzod_pkg::DirStraight) == res_q.center_blocked))
    else $error("direction disagrees with blocked flag");
  a_counters_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (neg_q == '0 && high_q == '0))
    else $error("zone counters not cleared after frame");
`endif

endmodule

// ===== test/tb_top.sv =====
// Testbench: checks the disparity zone obstacle detector against a zone-count predictor.
`timescale 1ns / 1ps

module tb_top;
  import dzod_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int RandomPixels = 450;

  typedef struct packed {
    logic [11:0] row_width;
    logic [11:0] counted_rows;
    logic [11:0] center_begin;
    logic [11:0] center_end;
    logic [7:0]  high_threshold;
    logic [8:0]  negative_weight;
    logic [6:0]  center_percent;
  } zone_cfg_t;

  typedef enum logic {RowSetup, RowPixel} plan_kind_e;

  typedef struct {
    plan_kind_e kind;
    zone_cfg_t  cfg;
    pixel_t     px;
    bit         typed;
    result_t    res;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_data;

  dzod_stream_if #(.beat_t(pixel_t)) pixel_ch ();
  dzod_stream_if #(.beat_t(result_t)) result_ch ();

  disparity_zone_obstacle_detector_unit uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .pixel_in   (pixel_ch),
    .result_out (result_ch),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #5 clk = ~clk;

  zone_cfg_t cfg_now;
  logic [CntW-1:0] neg_count [3];
  logic [CntW-1:0] high_count [3];
  result_t decisions_due [$];
  plan_row_t plan [$];
  bit steady;
  bit hold_typed;
  result_t hold_res;
  int faults;
  int cycles;
  result_t seen, want, got;

  // Counts one pixel into its zone; on end of frame scores the zones and clears.
  function automatic bit advance_zones(input pixel_t p, output result_t r);
    logic [11:0] b, e;
    int z;
    longint unsigned rows_l, nw_l, pct_l;
    longint unsigned tot [3];
    longint unsigned num [3];
    longint unsigned den [3];
    bit blocked;
    r = '0;
    b = (cfg_now.center_begin < cfg_now.row_width) ? cfg_now.center_begin
                                                    : cfg_now.row_width;
    e = cfg_now.center_end;
    if (e < b) e = b;
    if (e > cfg_now.row_width) e = cfg_now.row_width;
    z = -1;
    if ({1'b0, p.row} < cfg_now.counted_rows) begin
      if ({1'b0, p.col} < b) z = 0;
      else if ({1'b0, p.col} < e) z = 1;
      else if ({1'b0, p.col} < cfg_now.row_width) z = 2;
    end
    if (z >= 0) begin
      if (p.disparity[8]) begin
        if (neg_count[z] != CntMax) neg_count[z] = neg_count[z] + 1'b1;
      end else if (p.disparity[7:0] >= cfg_now.high_threshold) begin
        if (high_count[z] != CntMax) high_count[z] = high_count[z] + 1'b1;
      end
    end
    if (!p.end_of_frame) return 1'b0;
    rows_l = cfg_now.counted_rows;
    nw_l = cfg_now.negative_weight;
    pct_l = cfg_now.center_percent;
    tot[0] = rows_l * b;
    tot[1] = rows_l * (e - b);
    tot[2] = rows_l * (cfg_now.row_width - e);
    for (int i = 0; i < 3; i++) begin
      if (tot[i] == 0) begin
        num[i] = 0;
        den[i] = 1;
      end else begin
        num[i] = nw_l * neg_count[i] + 64'd256 * high_count[i];
        den[i] = tot[i];
      end
    end
    blocked = num[1] * 100 >= pct_l * 256 * den[1];
    r.center_blocked = blocked;
    r.direction = !blocked ? DirStraight :
                  (num[0] * den[2] < num[2] * den[0]) ? DirPlus : DirMinus;
    r.center_high_count = high_count[1];
    r.center_negative_count = neg_count[1];
    for (int i = 0; i < 3; i++) begin
      neg_count[i] = '0;
      high_count[i] = '0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.data;
        if (decisions_due.size() == 0) begin
          $display("%0t: unexpected beat dir %0d blocked %0d high %0d neg %0d", $time,
                   got.direction, got.center_blocked, got.center_high_count,
                   got.center_negative_count);
          faults++;
        end else begin
          want = decisions_due.pop_front();
          if (got.direction != want.direction) begin
            $display("%0t: direction exp %0d got %0d", $time, want.direction, got.direction);
            faults++;
          end
          if (got.center_blocked != want.center_blocked) begin
            $display("%0t: center_blocked exp %0d got %0d", $time, want.center_blocked,
                     got.center_blocked);
            faults++;
          end
          if (got.center_high_count != want.center_high_count) begin
            $display("%0t: center_high_count exp %0d got %0d", $time,
                     want.center_high_count, got.center_high_count);
            faults++;
          end
          if (got.center_negative_count != want.center_negative_count) begin
            $display("%0t: center_negative_count exp %0d got %0d", $time,
                     want.center_negative_count, got.center_negative_count);
            faults++;
          end
        end
      end
      if (pixel_ch.valid && pixel_ch.ready) begin
        if (advance_zones(pixel_ch.data, seen)) begin
          decisions_due.push_back(hold_typed ? hold_res : seen);
        end
      end
    end
  end

  // Result sink with random stalls.
  initial begin
    int n;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      n = steady ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        result_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      @(negedge clk);
    end
  end

  task automatic send_pixel(pixel_t p, bit typed, result_t res);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      pixel_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    hold_typed = typed;
    hold_res = res;
    pixel_ch.data <= p;
    pixel_ch.valid <= 1'b1;
    do @(posedge clk); while (!pixel_ch.ready);
    @(negedge clk);
  endtask

  // Drain pending decisions, then give the datapath time to go idle.
  task automatic settle();
    pixel_ch.valid <= 1'b0;
    while (decisions_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic program_regs(zone_cfg_t c);
    write_reg(CfgFrameWidth, c.row_width);
    write_reg(CfgCountedRows, c.counted_rows);
    write_reg(CfgCenterBegin, c.center_begin);
    write_reg(CfgCenterEnd, c.center_end);
    write_reg(CfgHighThreshold, 12'(c.high_threshold));
    write_reg(CfgNegativeWeight, 12'(c.negative_weight));
    write_reg(CfgCenterPercent, 12'(c.center_percent));
    cfg_we <= 1'b0;
    cfg_now = c;
  endtask

  function automatic plan_row_t setup_row(int fw, int rows, int cb, int ce, int thr,
                                          int nw, int pct);
    plan_row_t t;
    t = '{RowSetup, '0, '0, 1'b0, '0};
    t.cfg.row_width = 12'(fw);
    t.cfg.counted_rows = 12'(rows);
    t.cfg.center_begin = 12'(cb);
    t.cfg.center_end = 12'(ce);
    t.cfg.high_threshold = 8'(thr);
    t.cfg.negative_weight = 9'(nw);
    t.cfg.center_percent = 7'(pct);
    return t;
  endfunction

  function automatic plan_row_t pixel_row(int d, int r, int c, bit eof);
    plan_row_t t;
    t = '{RowPixel, '0, '0, 1'b0, '0};
    t.px.disparity = 9'(d);
    t.px.row = 11'(r);
    t.px.col = 11'(c);
    t.px.end_of_frame = eof;
    return t;
  endfunction

  function automatic plan_row_t eof_row(int d, int r, int c, dir_e dir, bit blk, int hi,
                                        int ng);
    plan_row_t t;
    t = pixel_row(d, r, c, 1'b1);
    t.typed = 1'b1;
    t.res.direction = dir;
    t.res.center_blocked = blk;
    t.res.center_high_count = CntW'(hi);
    t.res.center_negative_count = CntW'(ng);
    return t;
  endfunction

  function automatic zone_cfg_t random_cfg();
    zone_cfg_t c;
    int fw, rows, cb, ce;
    case ($urandom_range(0, 9))
      0: fw = 1;
      1: fw = 2048;
      2: fw = $urandom_range(1, 4095);
      default: fw = $urandom_range(2, 16);
    endcase
    case ($urandom_range(0, 9))
      0: rows = 0;
      1: rows = 2048;
      2: rows = $urandom_range(0, 4095);
      default: rows = $urandom_range(1, 4);
    endcase
    case ($urandom_range(0, 9))
      0: cb = 0;
      1: cb = $urandom_range(0, 4095);
      default: cb = $urandom_range(0, fw);
    endcase
    case ($urandom_range(0, 9))
      0: ce = 0;
      1: ce = 4095;
      2: ce = $urandom_range(0, 4095);
      default: ce = $urandom_range(0, fw + 1);
    endcase
    c.row_width = 12'(fw);
    c.counted_rows = 12'(rows);
    c.center_begin = 12'(cb);
    c.center_end = 12'(ce);
    case ($urandom_range(0, 5))
      0: c.high_threshold = 8'd0;
      1: c.high_threshold = 8'd255;
      default: c.high_threshold = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 6))
      0: c.negative_weight = 9'd0;
      1: c.negative_weight = 9'd256;
      2: c.negative_weight = 9'd511;
      default: c.negative_weight = 9'($urandom_range(0, 256));
    endcase
    case ($urandom_range(0, 6))
      0: c.center_percent = 7'd0;
      1: c.center_percent = 7'd100;
      2: c.center_percent = 7'd127;
      default: c.center_percent = 7'($urandom_range(0, 100));
    endcase
    return c;
  endfunction

  function automatic pixel_t random_pixel(bit last);
    pixel_t p;
    int lim;
    case ($urandom_range(0, 9))
      0, 1, 2: p.disparity = {1'b1, 8'($urandom)};
      3, 4, 5: p.disparity = {1'b0, 8'($urandom_range(cfg_now.high_threshold, 255))};
      default: p.disparity = 9'($urandom);
    endcase
    lim = cfg_now.counted_rows + 1;
    if (lim > 2047) lim = 2047;
    p.row = ($urandom_range(0, 7) == 0) ? 11'($urandom) : 11'($urandom_range(0, lim));
    lim = cfg_now.row_width;
    if (lim > 2047) lim = 2047;
    p.col = ($urandom_range(0, 7) == 0) ? 11'($urandom) : 11'($urandom_range(0, lim));
    p.end_of_frame = last;
    return p;
  endfunction

  initial begin
    int sent, budget, len;
    pixel_ch.valid = 1'b0;
    pixel_ch.data = '0;
    result_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CfgFrameWidth;
    cfg_data = '0;
    rst_n = 1'b0;
    faults = 0;
    cycles = 0;
    steady = 1'b0;
    hold_typed = 1'b0;
    hold_res = '0;
    cfg_now = {FrameWidthRst, CountedRowsRst, CenterBeginRst, CenterEndRst,
               HighThresholdRst, NegativeWeightRst, CenterPercentRst};
    for (int i = 0; i < 3; i++) begin
      neg_count[i] = '0;
      high_count[i] = '0;
    end

    // reset config: empty frame, then zone edges, row cutoff and thresholds
    plan.push_back(eof_row(0, 0, 0, DirStraight, 1'b0, 0, 0));
    plan.push_back(pixel_row(255, 0, 160, 1'b0));
    plan.push_back(pixel_row(-256, 0, 543, 1'b0));
    plan.push_back(pixel_row(75, 5, 300, 1'b0));
    plan.push_back(pixel_row(74, 5, 301, 1'b0));
    plan.push_back(pixel_row(-1, 10, 200, 1'b0));
    plan.push_back(pixel_row(100, 359, 200, 1'b0));
    plan.push_back(pixel_row(100, 360, 200, 1'b0));
    plan.push_back(pixel_row(-7, 2047, 2047, 1'b0));
    plan.push_back(pixel_row(200, 0, 639, 1'b0));
    plan.push_back(pixel_row(200, 0, 640, 1'b0));
    plan.push_back(pixel_row(-5, 0, 0, 1'b0));
    plan.push_back(eof_row(80, 0, 159, DirStraight, 1'b0, 3, 2));
    // tiny frame: exact threshold hit with tied sides, then right side worse
    plan.push_back(setup_row(4, 1, 1, 3, 255, 256, 100));
    plan.push_back(pixel_row(255, 0, 1, 1'b0));
    plan.push_back(pixel_row(-1, 0, 2, 1'b0));
    plan.push_back(pixel_row(-256, 0, 0, 1'b0));
    plan.push_back(eof_row(255, 0, 3, DirMinus, 1'b1, 1, 1));
    plan.push_back(pixel_row(255, 0, 1, 1'b0));
    plan.push_back(pixel_row(255, 0, 2, 1'b0));
    plan.push_back(eof_row(-3, 0, 3, DirPlus, 1'b1, 2, 0));
    // empty center with zero percent, center_begin past the row width
    plan.push_back(setup_row(4, 1, 4095, 0, 0, 0, 0));
    plan.push_back(eof_row(0, 0, 2, DirMinus, 1'b1, 0, 0));
    // no rows counted
    plan.push_back(setup_row(2048, 0, 0, 2048, 128, 1, 1));
    plan.push_back(pixel_row(-1, 0, 5, 1'b0));
    plan.push_back(eof_row(200, 1, 1000, DirStraight, 1'b0, 0, 0));

    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == RowSetup) begin
        settle();
        program_regs(plan[i].cfg);
      end else begin
        send_pixel(plan[i].px, plan[i].typed, plan[i].res);
      end
    end

    sent = 0;
    while (sent < RandomPixels) begin
      settle();
      program_regs(random_cfg());
      steady = ($urandom_range(0, 3) == 0);
      budget = $urandom_range(25, 45);
      while (budget > 0) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          send_pixel(random_pixel(k == len - 1), 1'b0, '0);
        end
        sent += len;
        budget -= len;
      end
    end

    settle();
    if (faults == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/dzod_pkg.sv
hw/rtl/dzod_stream_if.sv
hw/rtl/dzod_ctrl.sv
hw/rtl/dzod_datapath.sv
hw/rtl/disparity_zone_obstacle_detector_unit.sv
test/tb_top.sv
